// File: rtl/rsbp_pkg.sv
// Shared definitions for the price-sorting record block.
// Holds sizes, the sequencer state type and the sequencer-to-datapath control bundle.
// No dependencies.
package rsbp_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int PRICE_W     = 24;
  localparam int POS_W       = 6;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int WORD_W      = IDX_W + PRICE_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_I,
    ST_LD_I,
    ST_CMP,
    ST_WB_I,
    ST_OUT
  } rsbp_state_t;

  // Control bundle from the sequencer to the datapath.
  typedef struct packed {
    logic             wr_load;
    logic             ld_cur;
    logic             cmp;
    logic             wb_i;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             emit;
    logic             emit_last;
  } rsbp_ctl_t;

endpackage

// File: rtl/rsbp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stores the record file (load position and price). No dependencies.
module rsbp_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 30,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              re,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/rsbp_seq.sv
// Sequencer for the price-sorting record block: load counter, sort loop
// indexes and output walk. Depends on rsbp_pkg.
module rsbp_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              last_record,
  input  logic              swap,
  output logic              busy,
  output rsbp_pkg::rsbp_ctl_t ctl
);

  rsbp_pkg::rsbp_state_t state, state_next;
  logic [rsbp_pkg::CNT_W-1:0] count, count_next;
  logic [rsbp_pkg::IDX_W-1:0] i, i_next;
  logic [rsbp_pkg::IDX_W-1:0] j, j_next;
  logic [rsbp_pkg::CNT_W-1:0] k, k_next;
  logic emit, emit_next;
  logic emit_last, emit_last_next;
  logic room;
  logic j_end;
  logic i_more;
  logic k_end;
  logic [rsbp_pkg::CNT_W-1:0] n_loaded;

  // Loop conditions derived from the counters.
  assign room     = count < rsbp_pkg::CNT_W'(rsbp_pkg::MAX_RECORDS);
  assign n_loaded = room ? count + rsbp_pkg::CNT_W'(1) : count;
  assign j_end    = (rsbp_pkg::CNT_W'(j) + rsbp_pkg::CNT_W'(1)) == count;
  assign i_more   = (rsbp_pkg::CNT_W'(i) + rsbp_pkg::CNT_W'(2)) < count;
  assign k_end    = (k + rsbp_pkg::CNT_W'(1)) == count;

  // Next state and counter updates.
  always_comb begin
    state_next     = state;
    count_next     = count;
    i_next         = i;
    j_next         = j;
    k_next         = k;
    emit_next      = 1'b0;
    emit_last_next = 1'b0;
    case (state)
      rsbp_pkg::ST_IDLE: begin
        if (start) begin
          count_next = n_loaded;
          if (last_record) begin
            i_next = '0;
            k_next = '0;
            if (n_loaded < rsbp_pkg::CNT_W'(2)) begin
              state_next = rsbp_pkg::ST_OUT;
            end else begin
              state_next = rsbp_pkg::ST_RD_I;
            end
          end
        end
      end
      rsbp_pkg::ST_RD_I: begin
        state_next = rsbp_pkg::ST_LD_I;
      end
      rsbp_pkg::ST_LD_I: begin
        j_next     = i + rsbp_pkg::IDX_W'(1);
        state_next = rsbp_pkg::ST_CMP;
      end
      rsbp_pkg::ST_CMP: begin
        if (j_end) begin
          state_next = rsbp_pkg::ST_WB_I;
        end else begin
          j_next = j + rsbp_pkg::IDX_W'(1);
        end
      end
      rsbp_pkg::ST_WB_I: begin
        if (i_more) begin
          i_next     = i + rsbp_pkg::IDX_W'(1);
          state_next = rsbp_pkg::ST_RD_I;
        end else begin
          k_next     = '0;
          state_next = rsbp_pkg::ST_OUT;
        end
      end
      rsbp_pkg::ST_OUT: begin
        emit_next      = 1'b1;
        emit_last_next = k_end;
        k_next         = k + rsbp_pkg::CNT_W'(1);
        if (k_end) begin
          count_next = '0;
          state_next = rsbp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rsbp_pkg::ST_IDLE;
      end
    endcase
  end

  // Control outputs to the datapath.
  always_comb begin
    busy          = state != rsbp_pkg::ST_IDLE;
    ctl.wr_load   = 1'b0;
    ctl.ld_cur    = 1'b0;
    ctl.cmp       = 1'b0;
    ctl.wb_i      = 1'b0;
    ctl.rd_en     = 1'b0;
    ctl.rd_addr   = '0;
    ctl.wr_addr   = '0;
    ctl.emit      = emit;
    ctl.emit_last = emit_last;
    case (state)
      rsbp_pkg::ST_IDLE: begin
        ctl.wr_load = start && room;
        ctl.wr_addr = count[rsbp_pkg::IDX_W-1:0];
      end
      rsbp_pkg::ST_RD_I: begin
        ctl.rd_en   = 1'b1;
        ctl.rd_addr = i;
      end
      rsbp_pkg::ST_LD_I: begin
        ctl.ld_cur  = 1'b1;
        ctl.rd_en   = 1'b1;
        ctl.rd_addr = i + rsbp_pkg::IDX_W'(1);
      end
      rsbp_pkg::ST_CMP: begin
        ctl.cmp     = 1'b1;
        ctl.wr_addr = j;
        ctl.rd_en   = !j_end;
        ctl.rd_addr = j + rsbp_pkg::IDX_W'(1);
      end
      rsbp_pkg::ST_WB_I: begin
        ctl.wb_i    = 1'b1;
        ctl.wr_addr = i;
      end
      rsbp_pkg::ST_OUT: begin
        ctl.rd_en   = 1'b1;
        ctl.rd_addr = k[rsbp_pkg::IDX_W-1:0];
      end
      default: begin
        ctl.rd_en = 1'b0;
      end
    endcase
  end

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rsbp_pkg::ST_IDLE;
      count     <= '0;
      i         <= '0;
      j         <= '0;
      k         <= '0;
      emit      <= 1'b0;
      emit_last <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      i         <= i_next;
      j         <= j_next;
      k         <= k_next;
      emit      <= emit_next;
      emit_last <= emit_last_next;
    end
  end

  // The file never holds more than its capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= rsbp_pkg::CNT_W'(rsbp_pkg::MAX_RECORDS))
    else $error("record count above capacity");

  // Inner index stays above the outer index and inside the loaded set.
  a_j_range: assert property (@(posedge clk) disable iff (rst)
    (state == rsbp_pkg::ST_CMP) |->
      (j > i) && (rsbp_pkg::CNT_W'(j) < count))
    else $error("inner sort index out of range");

  // A swap write never lands on the entry being read next.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (ctl.cmp && swap && ctl.rd_en) |-> (ctl.wr_addr != ctl.rd_addr))
    else $error("write and read address collide");

  // The final beat is always followed by a return to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (state == rsbp_pkg::ST_OUT && k_end) |=> (state == rsbp_pkg::ST_IDLE))
    else $error("output walk did not end in idle");

endmodule

// File: rtl/record_sort_by_price_top.sv
// Top level of the price-sorting record block: record file, held entry
// register and shared compare unit. Depends on rsbp_pkg, rsbp_ram and rsbp_seq.
//
//  channel   handshake                 payload
//  input     start / busy              price_cents, last_record
//  result    result_strobe (no stall)  record_position, price_out, final_result
//
// Records are loaded while the block is idle. The set then sorts with one
// compare per cycle within each pass on the single compare unit fed by the single
// read port of the record file; results follow one per cycle.
// busy is high from the accepted last record until the final beat is on the ports.
// rst is synchronous and clears the count and sequencer; file contents are kept.
// The receiver cannot stall: each result beat is valid for exactly one cycle.
module record_sort_by_price_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [rsbp_pkg::PRICE_W-1:0] price_cents,
  input  logic                         last_record,
  output logic                         result_strobe,
  output logic [rsbp_pkg::POS_W-1:0]   record_position,
  output logic [rsbp_pkg::PRICE_W-1:0] price_out,
  output logic                         final_result
);

  rsbp_pkg::rsbp_ctl_t ctl;
  logic [rsbp_pkg::WORD_W-1:0] rd_data;
  logic [rsbp_pkg::WORD_W-1:0] wr_data;
  logic [rsbp_pkg::WORD_W-1:0] cur;
  logic                        we;
  logic                        swap;

  rsbp_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .last_record (last_record),
    .swap        (swap),
    .busy        (busy),
    .ctl         (ctl)
  );

  // Shared compare unit: held entry strictly above the entry just read.
  assign swap = cur[rsbp_pkg::PRICE_W-1:0] > rd_data[rsbp_pkg::PRICE_W-1:0];

  // Write selection: a new record on load, otherwise the held entry.
  assign we      = ctl.wr_load || ctl.wb_i || (ctl.cmp && swap);
  assign wr_data = ctl.wr_load ? {ctl.wr_addr, price_cents} : cur;

  rsbp_ram #(
    .DEPTH (rsbp_pkg::MAX_RECORDS),
    .WIDTH (rsbp_pkg::WORD_W)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .wr_addr (ctl.wr_addr),
    .wr_data (wr_data),
    .re      (ctl.rd_en),
    .rd_addr (ctl.rd_addr),
    .rd_data (rd_data)
  );

  // Held entry i: loaded at the start of each pass, replaced on every swap.
  always_ff @(posedge clk) begin
    if (ctl.ld_cur || (ctl.cmp && swap)) begin
      cur <= rd_data;
    end
  end

  // Result beat comes straight from the registered read data.
  assign result_strobe   = ctl.emit;
  assign final_result    = ctl.emit_last;
  assign price_out       = rd_data[rsbp_pkg::PRICE_W-1:0];
  assign record_position =
    rsbp_pkg::POS_W'(rd_data[rsbp_pkg::WORD_W-1:rsbp_pkg::PRICE_W]);

  // Results only appear while the block is busy or on its final beat.
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !final_result) |-> busy)
    else $error("result beat outside of an output run");

  // The final beat closes the run.
  a_final_closes: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && final_result) |=> !result_strobe)
    else $error("result beat after the final beat");

  // A flagged final beat is never shown without its strobe.
  a_final_strobe: assert property (@(posedge clk) disable iff (rst)
    final_result |-> result_strobe)
    else $error("final flag without strobe");

endmodule

// File: dv/record_sort_by_price_top_tb.sv
// Self-checking testbench for record_sort_by_price_top: loads sets of prices, predicts
// the exchange-sorted run of each set and checks every result beat field by field.
// Depends on rsbp_pkg and the record_sort_by_price_top RTL.
`timescale 1ns / 100ps

module record_sort_by_price_top_tb;

  localparam int RANDOM_ITEMS = 110;
  localparam int MAX_BIG_SETS = 2;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum int {
    PM_FULL,
    PM_NARROW,
    PM_EXTREME
  } price_mode_t;

  typedef struct {
    logic [rsbp_pkg::POS_W-1:0]   position;
    logic [rsbp_pkg::PRICE_W-1:0] cents;
    logic                         is_final;
  } sorted_beat_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic [rsbp_pkg::PRICE_W-1:0] price_cents = '0;
  logic                         last_record = 1'b0;
  logic                         busy;
  logic                         result_strobe;
  logic [rsbp_pkg::POS_W-1:0]   record_position;
  logic [rsbp_pkg::PRICE_W-1:0] price_out;
  logic                         final_result;

  // Shadow of the record file: prices and load positions of the set being built.
  logic [rsbp_pkg::PRICE_W-1:0] held_price[rsbp_pkg::MAX_RECORDS];
  logic [rsbp_pkg::POS_W-1:0]   held_slot[rsbp_pkg::MAX_RECORDS];
  int                           held_count = 0;

  sorted_beat_t       sorted_due[$];
  int                 mismatch_count = 0;
  int                 cycle_count = 0;
  bit                 no_idle = 1'b0;

  record_sort_by_price_top dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .price_cents     (price_cents),
    .last_record     (last_record),
    .result_strobe   (result_strobe),
    .record_position (record_position),
    .price_out       (price_out),
    .final_result    (final_result)
  );

  always #1 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Exchange sort of the held set, then queue one expected beat per record.
  task automatic predict_sorted_run();
    logic [rsbp_pkg::PRICE_W-1:0] tmp_price;
    logic [rsbp_pkg::POS_W-1:0]   tmp_slot;
    sorted_beat_t                 beat;
    for (int i = 0; i + 1 < held_count; i++) begin
      for (int j = i; j < held_count; j++) begin
        if (held_price[i] > held_price[j]) begin
          tmp_price     = held_price[i];
          held_price[i] = held_price[j];
          held_price[j] = tmp_price;
          tmp_slot      = held_slot[i];
          held_slot[i]  = held_slot[j];
          held_slot[j]  = tmp_slot;
        end
      end
    end
    for (int k = 0; k < held_count; k++) begin
      beat.position = held_slot[k];
      beat.cents    = held_price[k];
      beat.is_final = (k + 1 == held_count);
      sorted_due.push_back(beat);
    end
    held_count = 0;
  endtask

  // Model one accepted record: store it unless the file is full, sort on the last one.
  task automatic book_record(input logic [rsbp_pkg::PRICE_W-1:0] cents,
                             input logic is_last);
    if (held_count < rsbp_pkg::MAX_RECORDS) begin
      held_price[held_count] = cents;
      held_slot[held_count]  = held_count[rsbp_pkg::POS_W-1:0];
      held_count++;
    end
    if (is_last) predict_sorted_run();
  endtask

  // Drive one record beat after a random gap and hold it until the block takes it.
  // busy is sampled at the falling edge, so the accept decision never races the DUT.
  task automatic send_record(input logic [rsbp_pkg::PRICE_W-1:0] cents,
                             input logic is_last);
    int gap;
    bit taken;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    price_cents <= cents;
    last_record <= is_last;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    book_record(cents, is_last);
  endtask

  // Hold the sender off until every expected beat has arrived.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (sorted_due.size() != 0);
  endtask

  function automatic logic [rsbp_pkg::PRICE_W-1:0] pick_price(input price_mode_t mode);
    logic [rsbp_pkg::PRICE_W-1:0] corner[6];
    corner = '{24'h000000, 24'h000001, 24'h7FFFFF, 24'h800000, 24'hFFFFFE, 24'hFFFFFF};
    case (mode)
      PM_NARROW: begin
        return rsbp_pkg::PRICE_W'($urandom_range(0, 7));
      end
      PM_EXTREME: begin
        return corner[$urandom_range(0, 5)];
      end
      default: begin
        return rsbp_pkg::PRICE_W'($urandom);
      end
    endcase
  endfunction

  // Result checker: every strobed beat is compared with the oldest expectation.
  always @(negedge clk) begin
    sorted_beat_t want;
    if (!rst && result_strobe) begin
      if (sorted_due.size() == 0) begin
        $error("result beat with nothing expected: position %0d price %0d",
               record_position, price_out);
        mismatch_count++;
      end else begin
        want = sorted_due.pop_front();
        if (record_position !== want.position) begin
          $error("record_position: expected %0d, got %0d", want.position, record_position);
          mismatch_count++;
        end
        if (price_out !== want.cents) begin
          $error("price_out: expected %0d, got %0d", want.cents, price_out);
          mismatch_count++;
        end
        if (final_result !== want.is_final) begin
          $error("final_result: expected %0b, got %0b", want.is_final, final_result);
          mismatch_count++;
        end
      end
    end
  end

  // A set of one record: the run is a single final beat.
  task automatic test_single_record();
    send_record(24'hFFFFFF, 1'b1);
  endtask

  // Extremes of the price and repeated prices, so ties fall as the sort leaves them.
  task automatic test_extremes_and_ties();
    logic [rsbp_pkg::PRICE_W-1:0] prices[9];
    prices = '{24'hFFFFFF, 24'h000000, 24'h800000, 24'h000000, 24'hFFFFFF,
               24'h7FFFFF, 24'h000001, 24'h800000, 24'h555555};
    for (int k = 0; k < 9; k++) send_record(prices[k], k == 8);
  endtask

  // Strictly descending set, then an already ascending one, sent back to back.
  task automatic test_ordered_sets();
    for (int k = 0; k < 6; k++) send_record(rsbp_pkg::PRICE_W'(600 - 100 * k), k == 5);
    for (int k = 0; k < 6; k++) send_record(rsbp_pkg::PRICE_W'(10 * k), k == 5);
  endtask

  // The sender waits for a whole run to drain before the next set starts.
  task automatic test_drained_restart();
    send_record(24'h0000AA, 1'b0);
    send_record(24'h0000AA, 1'b0);
    send_record(24'h000055, 1'b1);
    wait_drained();
    send_record(24'h123456, 1'b0);
    send_record(24'hABCDEF, 1'b1);
  endtask

  // A full file: 64 records are kept and the marked last one past capacity is dropped,
  // yet it still starts the sort of what is stored.
  task automatic test_store_full();
    no_idle = 1'b1;
    for (int k = 0; k <= rsbp_pkg::MAX_RECORDS; k++) begin
      send_record(rsbp_pkg::PRICE_W'($urandom_range(0, 40)), k == rsbp_pkg::MAX_RECORDS);
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  // Random sets: mostly small ones with varied price spreads, a few near capacity.
  task automatic test_random_sets();
    int          sent;
    int          set_len;
    int          big_sets;
    price_mode_t mode;
    sent     = 0;
    big_sets = 0;
    while (sent < RANDOM_ITEMS) begin
      if (big_sets < MAX_BIG_SETS && $urandom_range(0, 14) == 0) begin
        set_len = $urandom_range(rsbp_pkg::MAX_RECORDS - 2, rsbp_pkg::MAX_RECORDS + 4);
        big_sets++;
      end else begin
        set_len = $urandom_range(1, 12);
      end
      mode    = price_mode_t'($urandom_range(0, 2));
      no_idle = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < set_len; k++) begin
        send_record(pick_price(mode), k == set_len - 1);
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_record();
    test_extremes_and_ties();
    test_ordered_sets();
    test_drained_restart();
    test_store_full();
    test_random_sets();

    // Let the last run drain, then watch for stray beats.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/rsbp_pkg.sv
rtl/rsbp_ram.sv
rtl/rsbp_seq.sv
rtl/record_sort_by_price_top.sv
dv/record_sort_by_price_top_tb.sv
